// ----- sv/scfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scfa_pkg;

   localparam int WHEEL_COUNT    = 4;
   localparam int WHEEL_W        = $clog2(WHEEL_COUNT);
   localparam int FOUR_FRAME_LEN = 5 + WHEEL_COUNT * 8;
   localparam int IDX_W          = $clog2(FOUR_FRAME_LEN);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_W          = 112;
   localparam int RSP_W          = 16;
   localparam int CSR_W          = 16;
   localparam int CSR_IDX_W      = 3;

   // frame bytes
   localparam logic [7:0] FN_ENABLE    = 8'hF3;
   localparam logic [7:0] FN_VELOCITY  = 8'hF6;
   localparam logic [7:0] FN_STOP      = 8'hFE;
   localparam logic [7:0] FN_SYNC      = 8'hFF;
   localparam logic [7:0] FN_MULTI     = 8'hAA;
   localparam logic [7:0] KEY_ENABLE   = 8'hAB;
   localparam logic [7:0] KEY_STOP     = 8'h98;
   localparam logic [7:0] KEY_SYNC     = 8'h66;
   localparam logic [7:0] ACK_OK       = 8'h02;

   // configuration reset values
   localparam logic [7:0]  RST_FRAME_TAIL   = 8'd107;
   localparam logic [7:0]  RST_BROADCAST_ID = 8'd0;
   localparam logic        RST_ACK_ENABLE   = 1'b1;
   localparam logic [15:0] RST_TIMEOUT      = 16'd20;
   localparam logic [14:0] RST_MAX_SPEED    = 15'd3000;
   localparam logic [7:0]  RST_WHEEL_BASE   = 8'd1;
   localparam logic [WHEEL_COUNT-1:0] RST_FWD_MASK = WHEEL_COUNT'(9);

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_FRAME_TAIL       = 3'd0,
      CFG_BROADCAST_ID     = 3'd1,
      CFG_ACK_ENABLE       = 3'd2,
      CFG_TIMEOUT_TICKS    = 3'd3,
      CFG_SPEED_LIMIT      = 3'd4,
      CFG_WHEEL_BASE_ID    = 3'd5,
      CFG_FORWARD_DIR_MASK = 3'd6
   } cfg_index_type;

   typedef enum logic [2:0] {
      OP_ENABLE   = 3'd0,
      OP_VELOCITY = 3'd1,
      OP_STOP     = 3'd2,
      OP_SYNC     = 3'd3,
      OP_FOUR     = 3'd4,
      OP_RX       = 3'd5,
      OP_TICK     = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_SENT    = 3'd0,
      ST_ACK     = 3'd1,
      ST_INVALID = 3'd2,
      ST_TIMEOUT = 3'd3,
      ST_BUSY    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_FRAME  = 2'd1,
      BK_STATUS = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [7:0]                  frame_tail;
      logic [7:0]                  broadcast_id;
      logic                        ack_enable;
      logic [15:0]                 timeout_ticks;
      logic [14:0]                 speed_limit;
      logic [7:0]                  wheel_base_id;
      logic [WHEEL_COUNT-1:0]      forward_dir_mask;
   } cfg_type;

   // request payload, lowest field in the lowest bits
   typedef struct packed {
      logic [5:0]                  pad;
      logic [7:0]                  rx_byte;
      logic [WHEEL_COUNT-1:0][15:0] wheel_speed;
      logic [7:0]                  acceleration;
      logic [15:0]                 speed;
      logic                        direction;
      logic                        flag;
      logic [7:0]                  motor_id;
   } req_payload_type;

   typedef struct packed {
      op_type                      op;
      logic [7:0]                  motor_id;
      logic                        flag;
      logic                        direction;
      logic [15:0]                 speed;
      logic [7:0]                  acceleration;
      logic [WHEEL_COUNT-1:0][15:0] wheel_mag;
      logic [WHEEL_COUNT-1:0]      wheel_dir;
      logic                        speed_ok;
      logic [7:0]                  rx_byte;
   } cmd_type;

endpackage

`default_nettype wire

// ----- sv/scfa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scfa_front (
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [2:0]                  req_tuser,
   input  wire logic [scfa_pkg::REQ_W-1:0]  req_tdata,
   input  wire scfa_pkg::cfg_type           cfg,
   input  wire logic                        q_ready,
   output logic                             q_push,
   output scfa_pkg::cmd_type                q_data
);
   import scfa_pkg::*;

   req_payload_type pl;
   logic            known;
   logic            neg;

   assign pl = req_payload_type'(req_tdata);
   assign req_tready = q_ready;
   assign q_push = req_tvalid & q_ready & known;

   always_comb begin
      known = 1'b1;
      q_data.op = OP_TICK;
      unique case (req_tuser)
         OP_ENABLE:   q_data.op = OP_ENABLE;
         OP_VELOCITY: q_data.op = OP_VELOCITY;
         OP_STOP:     q_data.op = OP_STOP;
         OP_SYNC:     q_data.op = OP_SYNC;
         OP_FOUR:     q_data.op = OP_FOUR;
         OP_RX:       q_data.op = OP_RX;
         OP_TICK:     q_data.op = OP_TICK;
         default:     known = 1'b0;  // unused action is dropped here
      endcase

      q_data.motor_id     = pl.motor_id;
      q_data.flag         = pl.flag;
      q_data.direction    = pl.direction;
      q_data.speed        = pl.speed;
      q_data.acceleration = pl.acceleration;
      q_data.rx_byte      = pl.rx_byte;
      q_data.speed_ok     = 1'b1;
      neg                 = 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         neg = pl.wheel_speed[i][15];
         q_data.wheel_mag[i] = neg ? 16'(-pl.wheel_speed[i]) : pl.wheel_speed[i];
         q_data.wheel_dir[i] = cfg.forward_dir_mask[i] ^ neg;
         if (q_data.wheel_mag[i] > {1'b0, cfg.speed_limit}) begin
            q_data.speed_ok = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/scfa_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scfa_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire scfa_pkg::cmd_type  push_data,
   output logic                    ready,
   input  wire logic               pop,
   output logic                    valid,
   output scfa_pkg::cmd_type       pop_data
);
   import scfa_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign ready    = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ready;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/scfa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scfa_back #(
   parameter int ACK_SCAN_LIMIT = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire scfa_pkg::cfg_type           cfg,
   input  wire logic                        q_valid,
   input  wire scfa_pkg::cmd_type           q_data,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   output logic [scfa_pkg::RSP_W-1:0]       rsp_tdata
);
   import scfa_pkg::*;

   localparam int SCAN_W = $clog2(ACK_SCAN_LIMIT + 1);

   function automatic logic is_frame_op(op_type op);
      return op == OP_ENABLE || op == OP_VELOCITY || op == OP_STOP ||
             op == OP_SYNC || op == OP_FOUR;
   endfunction

   function automatic logic [IDX_W-1:0] frame_last(op_type op);
      logic [IDX_W-1:0] n;
      n = IDX_W'(FOUR_FRAME_LEN - 1);
      unique case (op)
         OP_ENABLE:   n = IDX_W'(5);
         OP_VELOCITY: n = IDX_W'(7);
         OP_STOP:     n = IDX_W'(4);
         OP_SYNC:     n = IDX_W'(3);
         default:     n = IDX_W'(FOUR_FRAME_LEN - 1);
      endcase
      return n;
   endfunction

   function automatic logic [7:0] frame_byte(cmd_type c, logic [IDX_W-1:0] idx,
                                             cfg_type g);
      logic [IDX_W-1:0]   rel;
      logic [WHEEL_W-1:0] w;
      logic [2:0]         pos;
      logic [7:0]         b;
      rel = idx - IDX_W'(4);
      w   = rel[WHEEL_W+2:3];
      pos = rel[2:0];
      b   = g.frame_tail;
      unique case (c.op)
         OP_ENABLE: begin
            unique case (idx)
               IDX_W'(0): b = c.motor_id;
               IDX_W'(1): b = FN_ENABLE;
               IDX_W'(2): b = KEY_ENABLE;
               IDX_W'(3): b = {7'd0, c.flag};
               IDX_W'(4): b = 8'd0;
               default:   b = g.frame_tail;
            endcase
         end
         OP_VELOCITY: begin
            unique case (idx)
               IDX_W'(0): b = c.motor_id;
               IDX_W'(1): b = FN_VELOCITY;
               IDX_W'(2): b = {7'd0, c.direction};
               IDX_W'(3): b = c.speed[15:8];
               IDX_W'(4): b = c.speed[7:0];
               IDX_W'(5): b = c.acceleration;
               IDX_W'(6): b = {7'd0, c.flag};
               default:   b = g.frame_tail;
            endcase
         end
         OP_STOP: begin
            unique case (idx)
               IDX_W'(0): b = c.motor_id;
               IDX_W'(1): b = FN_STOP;
               IDX_W'(2): b = KEY_STOP;
               IDX_W'(3): b = {7'd0, c.flag};
               default:   b = g.frame_tail;
            endcase
         end
         OP_SYNC: begin
            unique case (idx)
               IDX_W'(0): b = g.broadcast_id;
               IDX_W'(1): b = FN_SYNC;
               IDX_W'(2): b = KEY_SYNC;
               default:   b = g.frame_tail;
            endcase
         end
         OP_FOUR: begin
            priority if (idx == IDX_W'(0)) begin
               b = g.broadcast_id;
            end else if (idx == IDX_W'(1)) begin
               b = FN_MULTI;
            end else if (idx == IDX_W'(2)) begin
               b = 8'(FOUR_FRAME_LEN / 256);
            end else if (idx == IDX_W'(3)) begin
               b = 8'(FOUR_FRAME_LEN % 256);
            end else if (idx == IDX_W'(FOUR_FRAME_LEN - 1)) begin
               b = g.frame_tail;
            end else begin
               // one 8-byte velocity sub-frame per wheel
               unique case (pos)
                  3'd0:    b = g.wheel_base_id + 8'(w);
                  3'd1:    b = FN_VELOCITY;
                  3'd2:    b = {7'd0, c.wheel_dir[w]};
                  3'd3:    b = c.wheel_mag[w][15:8];
                  3'd4:    b = c.wheel_mag[w][7:0];
                  3'd5:    b = c.acceleration;
                  3'd6:    b = 8'd0;
                  default: b = g.frame_tail;
               endcase
            end
         end
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               wait_start_ff, wait_start_in;
   status_type         trail_ff, trail_in;

   logic               waiting_ff, waiting_in;
   logic [7:0]         expect_id_ff, expect_id_in;
   logic [7:0]         expect_fn_ff, expect_fn_in;
   logic [7:0]         window_ff [3];
   logic [7:0]         window_in [3];
   logic [1:0]         fill_ff, fill_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic [15:0]        elapsed_ff, elapsed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free, take, start_frame, frame_done;
   logic               may_wait;
   logic [SCAN_W-1:0]  scan_next;
   logic [15:0]        elapsed_next;

   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign take        = (state_ff == BK_IDLE) & q_valid & out_free;
   assign start_frame = take & is_frame_op(q_data.op) & ~waiting_ff &
                        ((q_data.op != OP_FOUR) | q_data.speed_ok);
   assign frame_done  = idx_ff == frame_last(cmd_ff.op);
   assign q_pop       = take;

   assign may_wait     = (q_data.op == OP_FOUR) |
                         ((q_data.op != OP_SYNC) & (q_data.motor_id != cfg.broadcast_id));
   assign scan_next    = scan_ff + 1'b1;
   assign elapsed_next = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start_frame) begin
               state_in = BK_FRAME;
            end
         end
         BK_FRAME: begin
            if (out_free && frame_done) begin
               state_in = wait_start_ff ? BK_IDLE : BK_STATUS;
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      wait_start_in = wait_start_ff;
      trail_in      = trail_ff;
      waiting_in    = waiting_ff;
      expect_id_in  = expect_id_ff;
      expect_fn_in  = expect_fn_ff;
      window_in     = window_ff;
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      elapsed_in    = elapsed_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (take) begin
               if (is_frame_op(q_data.op) && waiting_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = 1'b1;
                  rsp_byte_in   = 8'd0;
                  rsp_status_in = ST_BUSY;
                  rsp_last_in   = 1'b1;
               end else if (q_data.op == OP_FOUR && !q_data.speed_ok) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = 1'b1;
                  rsp_byte_in   = 8'd0;
                  rsp_status_in = ST_INVALID;
                  rsp_last_in   = 1'b1;
               end else if (is_frame_op(q_data.op)) begin
                  cmd_in        = q_data;
                  idx_in        = '0;
                  wait_start_in = may_wait & cfg.ack_enable & (cfg.timeout_ticks != 16'd0);
                  trail_in      = (may_wait && cfg.ack_enable) ? ST_TIMEOUT : ST_SENT;
               end else if (q_data.op == OP_RX && waiting_ff) begin
                  if (fill_ff != 2'd3) begin
                     window_in[fill_ff] = q_data.rx_byte;
                     fill_in = fill_ff + 2'd1;
                  end else if (window_ff[0] == expect_id_ff &&
                               window_ff[1] == expect_fn_ff &&
                               window_ff[2] == ACK_OK &&
                               q_data.rx_byte == cfg.frame_tail) begin
                     waiting_in    = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = 1'b1;
                     rsp_byte_in   = 8'd0;
                     rsp_status_in = ST_ACK;
                     rsp_last_in   = 1'b1;
                  end else begin
                     window_in[0] = window_ff[1];
                     window_in[1] = window_ff[2];
                     window_in[2] = q_data.rx_byte;
                     scan_in      = scan_next;
                     if (scan_next >= SCAN_W'(ACK_SCAN_LIMIT)) begin
                        waiting_in    = 1'b0;
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = 1'b1;
                        rsp_byte_in   = 8'd0;
                        rsp_status_in = ST_TIMEOUT;
                        rsp_last_in   = 1'b1;
                     end
                  end
               end else if (q_data.op == OP_TICK && waiting_ff) begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= cfg.timeout_ticks) begin
                     waiting_in    = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = 1'b1;
                     rsp_byte_in   = 8'd0;
                     rsp_status_in = ST_TIMEOUT;
                     rsp_last_in   = 1'b1;
                  end
               end
            end
         end
         BK_FRAME: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = 1'b0;
               rsp_byte_in   = frame_byte(cmd_ff, idx_ff, cfg);
               rsp_status_in = ST_SENT;
               rsp_last_in   = frame_done & wait_start_ff;
               idx_in        = idx_ff + 1'b1;
               if (frame_done && wait_start_ff) begin
                  waiting_in   = 1'b1;
                  expect_id_in = (cmd_ff.op == OP_FOUR) ? cfg.wheel_base_id : cmd_ff.motor_id;
                  unique case (cmd_ff.op)
                     OP_ENABLE: expect_fn_in = FN_ENABLE;
                     OP_STOP:   expect_fn_in = FN_STOP;
                     default:   expect_fn_in = FN_VELOCITY;
                  endcase
                  fill_in      = 2'd0;
                  scan_in      = '0;
                  elapsed_in   = 16'd0;
               end
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = 1'b1;
               rsp_byte_in   = 8'd0;
               rsp_status_in = trail_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         waiting_ff   <= 1'b0;
         expect_id_ff <= 8'd0;
         expect_fn_ff <= 8'd0;
         fill_ff      <= 2'd0;
         scan_ff      <= '0;
         elapsed_ff   <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waiting_ff   <= waiting_in;
         expect_id_ff <= expect_id_in;
         expect_fn_ff <= expect_fn_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      wait_start_ff <= wait_start_in;
      trail_ff      <= trail_in;
      window_ff     <= window_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_byte_ff};

endmodule

`default_nettype wire

// ----- sv/stepper_command_framer_ack_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// path, back end idle: a frame's first byte passes the command queue, the FRAME state and
//   the response register; a status-only result passes the queue and the response register
// occupancy: a frame command holds the back end for a take, each frame byte and a status
//   report unless a wait starts, stalling while the output is held; other items need only a take
// a two-entry command queue lets requests be taken while a frame is being sent
// reset (synchronous): configuration returns to defaults, ack wait and queue are cleared

module stepper_command_framer_ack_core #(
   parameter int ACK_SCAN_LIMIT = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // action
   input  wire logic [2:0]                    req_tuser,
   // motor_id, flag, direction, speed, acceleration,
   // wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3, rx_byte
   input  wire logic [scfa_pkg::REQ_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // kind
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   // tx_byte, status
   output logic [scfa_pkg::RSP_W-1:0]         rsp_tdata,
   input  wire logic                          csr_we,
   input  wire logic [scfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [scfa_pkg::CSR_W-1:0]    csr_wdata
);
   import scfa_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_ready, q_push, q_valid, q_pop;
   cmd_type q_wr_data, q_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CFG_FRAME_TAIL:       cfg_in.frame_tail       = csr_wdata[7:0];
            CFG_BROADCAST_ID:     cfg_in.broadcast_id     = csr_wdata[7:0];
            CFG_ACK_ENABLE:       cfg_in.ack_enable       = csr_wdata[0];
            CFG_TIMEOUT_TICKS:    cfg_in.timeout_ticks    = csr_wdata;
            CFG_SPEED_LIMIT:      cfg_in.speed_limit      = csr_wdata[14:0];
            CFG_WHEEL_BASE_ID:    cfg_in.wheel_base_id    = csr_wdata[7:0];
            CFG_FORWARD_DIR_MASK: cfg_in.forward_dir_mask = csr_wdata[WHEEL_COUNT-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_tail       <= RST_FRAME_TAIL;
         cfg_ff.broadcast_id     <= RST_BROADCAST_ID;
         cfg_ff.ack_enable       <= RST_ACK_ENABLE;
         cfg_ff.timeout_ticks    <= RST_TIMEOUT;
         cfg_ff.speed_limit      <= RST_MAX_SPEED;
         cfg_ff.wheel_base_id    <= RST_WHEEL_BASE;
         cfg_ff.forward_dir_mask <= RST_FWD_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scfa_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_data     (q_wr_data)
   );

   scfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rd_data)
   );

   scfa_back #(
      .ACK_SCAN_LIMIT (ACK_SCAN_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_rd_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready)
      else $error("command pushed into a full queue");

   a_status_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("status report not final or carries a byte");

   a_byte_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[10:8] == ST_SENT)
      else $error("transmit byte carries a status code");

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import scfa_pkg::*;

   localparam int ACK_SCANS    = 16;
   localparam int QUIET_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      status_type status;
      logic       last;
   } frame_result;

   // predicts the frame bytes and ack outcome of each accepted command
   class frame_ack_scoreboard;
      cfg_type     cfg;
      bit          waiting;
      logic [7:0]  ack_id;
      logic [7:0]  ack_fn;
      logic [7:0]  window [3];
      int unsigned fill;
      int unsigned scans;
      logic [15:0] ticks;
      frame_result pending_results [$];
      int unsigned errors;

      function void clear();
         cfg.frame_tail       = RST_FRAME_TAIL;
         cfg.broadcast_id     = RST_BROADCAST_ID;
         cfg.ack_enable       = RST_ACK_ENABLE;
         cfg.timeout_ticks    = RST_TIMEOUT;
         cfg.speed_limit      = RST_MAX_SPEED;
         cfg.wheel_base_id    = RST_WHEEL_BASE;
         cfg.forward_dir_mask = RST_FWD_MASK;
         waiting = 1'b0;
         ack_id  = 8'h00;
         ack_fn  = 8'h00;
         window  = '{8'h00, 8'h00, 8'h00};
         fill    = 0;
         scans   = 0;
         ticks   = 16'h0000;
         pending_results.delete();
         errors  = 0;
      endfunction

      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CFG_FRAME_TAIL:       cfg.frame_tail       = val[7:0];
            CFG_BROADCAST_ID:     cfg.broadcast_id     = val[7:0];
            CFG_ACK_ENABLE:       cfg.ack_enable       = val[0];
            CFG_TIMEOUT_TICKS:    cfg.timeout_ticks    = val;
            CFG_SPEED_LIMIT:      cfg.speed_limit      = val[14:0];
            CFG_WHEEL_BASE_ID:    cfg.wheel_base_id    = val[7:0];
            CFG_FORWARD_DIR_MASK: cfg.forward_dir_mask = val[WHEEL_COUNT-1:0];
            default: ;
         endcase
      endfunction

      function void add(logic kind, logic [7:0] b, status_type st);
         frame_result r;
         r.kind    = kind;
         r.tx_byte = b;
         r.status  = st;
         r.last    = 1'b0;
         pending_results.push_back(r);
      endfunction

      function void tx(logic [7:0] b);
         add(1'b0, b, ST_SENT);
      endfunction

      function void report(status_type st);
         add(1'b1, 8'h00, st);
      endfunction

      function void after_frame(bit may_wait, logic [7:0] id, logic [7:0] fn);
         if (!may_wait || !cfg.ack_enable) begin
            report(ST_SENT);
         end else if (cfg.timeout_ticks == 16'h0000) begin
            report(ST_TIMEOUT);
         end else begin
            waiting = 1'b1;
            ack_id  = id;
            ack_fn  = fn;
            fill    = 0;
            scans   = 0;
            ticks   = 16'h0000;
            window  = '{8'h00, 8'h00, 8'h00};
         end
      endfunction

      function void take_command(logic [2:0] act, req_payload_type p);
         int unsigned queued;
         int          i;
         bit          speeds_ok;
         logic [15:0] mags [WHEEL_COUNT];
         frame_result r;
         queued = pending_results.size();
         if (act <= OP_FOUR && waiting) begin
            report(ST_BUSY);
         end else begin
            case (act)
               OP_ENABLE: begin
                  tx(p.motor_id); tx(FN_ENABLE); tx(KEY_ENABLE); tx({7'd0, p.flag});
                  tx(8'h00); tx(cfg.frame_tail);
                  after_frame(p.motor_id != cfg.broadcast_id, p.motor_id, FN_ENABLE);
               end
               OP_VELOCITY: begin
                  tx(p.motor_id); tx(FN_VELOCITY); tx({7'd0, p.direction});
                  tx(p.speed[15:8]); tx(p.speed[7:0]); tx(p.acceleration);
                  tx({7'd0, p.flag}); tx(cfg.frame_tail);
                  after_frame(p.motor_id != cfg.broadcast_id, p.motor_id, FN_VELOCITY);
               end
               OP_STOP: begin
                  tx(p.motor_id); tx(FN_STOP); tx(KEY_STOP); tx({7'd0, p.flag});
                  tx(cfg.frame_tail);
                  after_frame(p.motor_id != cfg.broadcast_id, p.motor_id, FN_STOP);
               end
               OP_SYNC: begin
                  tx(cfg.broadcast_id); tx(FN_SYNC); tx(KEY_SYNC); tx(cfg.frame_tail);
                  after_frame(1'b0, 8'h00, 8'h00);
               end
               OP_FOUR: begin
                  speeds_ok = 1'b1;
                  for (i = 0; i < WHEEL_COUNT; i++) begin
                     mags[i] = p.wheel_speed[i][15] ? -p.wheel_speed[i] : p.wheel_speed[i];
                     if (mags[i] > {1'b0, cfg.speed_limit}) speeds_ok = 1'b0;
                  end
                  if (!speeds_ok) begin
                     report(ST_INVALID);
                  end else begin
                     tx(cfg.broadcast_id); tx(FN_MULTI);
                     tx(8'(FOUR_FRAME_LEN >> 8)); tx(8'(FOUR_FRAME_LEN));
                     for (i = 0; i < WHEEL_COUNT; i++) begin
                        tx(cfg.wheel_base_id + 8'(i)); tx(FN_VELOCITY);
                        // negative speed flips the forward bit
                        tx({7'd0, cfg.forward_dir_mask[i] ^ p.wheel_speed[i][15]});
                        tx(mags[i][15:8]); tx(mags[i][7:0]); tx(p.acceleration);
                        tx(8'h00); tx(cfg.frame_tail);
                     end
                     tx(cfg.frame_tail);
                     after_frame(1'b1, cfg.wheel_base_id, FN_VELOCITY);
                  end
               end
               OP_RX: begin
                  if (waiting) begin
                     if (fill < 3) begin
                        window[fill] = p.rx_byte;
                        fill++;
                     end else if (window[0] == ack_id && window[1] == ack_fn &&
                                  window[2] == ACK_OK && p.rx_byte == cfg.frame_tail) begin
                        waiting = 1'b0;
                        report(ST_ACK);
                     end else begin
                        window[0] = window[1];
                        window[1] = window[2];
                        window[2] = p.rx_byte;
                        scans++;
                        if (scans >= ACK_SCANS) begin
                           waiting = 1'b0;
                           report(ST_TIMEOUT);
                        end
                     end
                  end
               end
               OP_TICK: begin
                  if (waiting) begin
                     if (ticks != 16'hFFFF) ticks++;
                     if (ticks >= cfg.timeout_ticks) begin
                        waiting = 1'b0;
                        report(ST_TIMEOUT);
                     end
                  end
               end
               default: ;
            endcase
         end
         if (pending_results.size() > queued) begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
         end
      endfunction

      function void match_result(frame_result got);
         frame_result want;
         if (pending_results.size() == 0) begin
            $display({"%0t: unexpected result, expected none, got kind %0d byte %02h",
                      " status %0d last %0d"},
                     $time, got.kind, got.tx_byte, got.status, got.last);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
             got.status !== want.status || got.last !== want.last) begin
            $display({"%0t: result mismatch, expected kind %0d byte %02h status %0d",
                      " last %0d, got kind %0d byte %02h status %0d last %0d"},
                     $time, want.kind, want.tx_byte, want.status, want.last,
                     got.kind, got.tx_byte, got.status, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [2:0]            req_tuser = OP_TICK;
   req_payload_type       req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   frame_ack_scoreboard frame_check;
   cfg_type             cur_cfg;
   int                  req_gap_pct = 38;
   int                  rsp_stall_pct = 38;
   int                  item_count = 0;
   int                  cycle_count = 0;

   stepper_command_framer_ack_core #(
      .ACK_SCAN_LIMIT(ACK_SCANS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // both channels are sampled at the edge, before any update of that edge lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) frame_check.take_command(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            frame_check.match_result('{kind: rsp_tuser, tx_byte: rsp_tdata[7:0],
                                       status: status_type'(rsp_tdata[10:8]),
                                       last: rsp_tlast});
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_payload_type rand_payload();
      logic [127:0]    r;
      req_payload_type p;
      r = {$urandom, $urandom, $urandom, $urandom};
      p = r[REQ_W-1:0];
      p.pad = '0;
      return p;
   endfunction

   function automatic logic [15:0] rand_wheel(logic [14:0] limit);
      logic [15:0] m;
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
         2: m = {1'b0, limit} + 16'($urandom_range(1));
         default: m = 16'($urandom_range(limit));
      endcase
      return ($urandom_range(1) != 0) ? -m : m;
   endfunction

   function automatic cfg_type rand_config();
      cfg_type c;
      c.frame_tail       = 8'($urandom);
      c.broadcast_id     = 8'($urandom);
      c.ack_enable       = ($urandom_range(3) != 0);
      c.timeout_ticks    = 16'($urandom_range(30));
      c.speed_limit      = 15'($urandom_range(32767, 200));
      c.wheel_base_id    = 8'($urandom_range(252, 1));
      c.forward_dir_mask = WHEEL_COUNT'($urandom);
      return c;
   endfunction

   task automatic send_item(logic [2:0] act, req_payload_type p);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= p;
      item_count++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_cmd(logic [2:0] act, logic [7:0] id, logic flg, logic dir,
                           logic [15:0] spd, logic [7:0] acc);
      req_payload_type p;
      p = rand_payload();
      p.motor_id     = id;
      p.flag         = flg;
      p.direction    = dir;
      p.speed        = spd;
      p.acceleration = acc;
      send_item(act, p);
   endtask

   task automatic send_wheels(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                              logic [15:0] w3);
      req_payload_type p;
      p = rand_payload();
      p.wheel_speed = {w3, w2, w1, w0};
      send_item(OP_FOUR, p);
   endtask

   task automatic send_rx(logic [7:0] b);
      req_payload_type p;
      p = rand_payload();
      p.rx_byte = b;
      send_item(OP_RX, p);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, rand_payload());
   endtask

   task automatic send_ack(logic [7:0] id, logic [7:0] fn);
      send_rx(id);
      send_rx(fn);
      send_rx(ACK_OK);
      send_rx(cur_cfg.frame_tail);
   endtask

   // hold the sender until every expected result is in, then let the queue settle
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frame_check.pending_results.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      frame_check.apply_write(idx, val);
      @(posedge clock);
   endtask

   task automatic load_config(cfg_type c);
      wait_quiet();
      write_csr(CFG_FRAME_TAIL, CSR_W'(c.frame_tail));
      write_csr(CFG_BROADCAST_ID, CSR_W'(c.broadcast_id));
      write_csr(CFG_ACK_ENABLE, CSR_W'(c.ack_enable));
      write_csr(CFG_TIMEOUT_TICKS, CSR_W'(c.timeout_ticks));
      write_csr(CFG_SPEED_LIMIT, CSR_W'(c.speed_limit));
      write_csr(CFG_WHEEL_BASE_ID, CSR_W'(c.wheel_base_id));
      write_csr(CFG_FORWARD_DIR_MASK, CSR_W'(c.forward_dir_mask));
      write_csr(CFG_UNUSED_INDEX, CSR_W'($urandom));
      csr_we  <= 1'b0;
      cur_cfg = c;
   endtask

   // one command followed by a reply pattern: clean ack, ticks, busy, line noise or an unused item
   task automatic run_episode();
      logic [2:0]      act;
      logic [7:0]      id;
      logic [7:0]      fn;
      req_payload_type p;
      int              i;
      act = 3'($urandom_range(OP_FOUR));
      p = rand_payload();
      if ($urandom_range(4) == 0) p.motor_id = cur_cfg.broadcast_id;
      for (i = 0; i < WHEEL_COUNT; i++) p.wheel_speed[i] = rand_wheel(cur_cfg.speed_limit);
      id = p.motor_id;
      case (act)
         OP_ENABLE:   fn = FN_ENABLE;
         OP_VELOCITY: fn = FN_VELOCITY;
         OP_STOP:     fn = FN_STOP;
         default: begin
            id = cur_cfg.wheel_base_id;
            fn = FN_VELOCITY;
         end
      endcase
      send_item(act, p);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            repeat ($urandom_range(3)) send_rx(8'($urandom));
            send_ack(id, fn);
         end
         5, 6: repeat ($urandom_range(25, 1)) send_tick();
         7: begin
            send_item(3'($urandom_range(OP_FOUR)), rand_payload());
            send_ack(id, fn);
         end
         8: repeat ($urandom_range(24)) send_rx(($urandom_range(1) != 0) ? 8'($urandom) : id);
         default: send_item(OP_UNUSED, rand_payload());
      endcase
   endtask

   task automatic run_items(int target);
      while (item_count < target) run_episode();
   endtask

   initial begin
      frame_check = new;
      frame_check.clear();
      cur_cfg = frame_check.cfg;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ack through a sliding window, broadcast, sync, ignored items, four-wheel frame, stop
      send_cmd(OP_ENABLE, 8'h12, 1'b1, 1'b0, 16'h0000, 8'h00);
      send_rx(8'h55);
      send_ack(8'h12, FN_ENABLE);
      send_cmd(OP_VELOCITY, cur_cfg.broadcast_id, 1'b1, 1'b1, 16'hFFFF, 8'hFF);
      send_item(OP_SYNC, rand_payload());
      send_item(OP_UNUSED, rand_payload());
      send_rx(8'hA5);
      send_tick();
      send_wheels(16'd0, 16'd3000, 16'(-3000), 16'hFFFF);
      send_cmd(OP_STOP, 8'h80, 1'b1, 1'b0, 16'h1234, 8'h56);
      // shorter timeout takes effect on the running wait
      wait_quiet();
      write_csr(CFG_TIMEOUT_TICKS, 16'd2);
      csr_we <= 1'b0;
      send_tick();
      send_tick();
      send_wheels(16'h8000, 16'd0, 16'd0, 16'd0);
      send_wheels(16'd0, 16'd0, 16'd3001, 16'd0);
      wait_quiet();
      write_csr(CFG_TIMEOUT_TICKS, 16'd0);
      csr_we <= 1'b0;
      send_cmd(OP_STOP, 8'hFF, 1'b0, 1'b0, 16'h0000, 8'h00);
      wait_quiet();
      write_csr(CFG_ACK_ENABLE, 16'd0);
      csr_we <= 1'b0;
      send_cmd(OP_ENABLE, 8'h09, 1'b0, 1'b1, 16'h0000, 8'h00);

      load_config('{frame_tail: 8'hFF, broadcast_id: 8'hFF, ack_enable: 1'b1,
                    timeout_ticks: 16'hFFFF, speed_limit: 15'h7FFF,
                    wheel_base_id: 8'd252, forward_dir_mask: WHEEL_COUNT'('1)});
      run_items(item_count + 30);

      load_config('{frame_tail: 8'h00, broadcast_id: 8'h00, ack_enable: 1'b0,
                    timeout_ticks: 16'h0000, speed_limit: 15'h0000,
                    wheel_base_id: 8'd1, forward_dir_mask: WHEEL_COUNT'('0)});
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      run_items(item_count + 30);
      req_gap_pct   = 38;
      rsp_stall_pct = 38;

      load_config(rand_config());
      run_items(item_count + 30);
      load_config(rand_config());
      run_items(item_count + 30);

      wait_quiet();
      if (frame_check.errors == 0 && frame_check.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/scfa_pkg.sv
sv/scfa_front.sv
sv/scfa_queue.sv
sv/scfa_back.sv
sv/stepper_command_framer_ack_core.sv
bench/tb_top.sv
